// File: hdl/pee_pkg.sv
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared character codes, status codes, beat types, controller states and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int DATA_W = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_DEPTH = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    status_t                  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_OPCHK,
    S_OPWAIT,
    S_OPCALC,
    S_DIVRUN,
    S_OPPUSH,
    S_END,
    S_LASTFLUSH,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic acc_digit;
    logic flush;
    logic note_under;
    logic load_opnd;
    logic calc;
    logic load_quot;
    logic op_push;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_op;
    logic is_div;
    logic is_last;
    logic under;
    logic rhs_zero;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates a postfix expression over 32-bit wrapping integers, one character
// per input beat, and returns one result beat per expression.
// ----------------------------------------------------------------------------
// Usage: the sender presents one ASCII character on in_data with in_valid;
// the character is taken at an edge where in_valid is high and in_stall low.
// Digits build a decimal number, + - * / operate on the stack, and any other
// character only ends a number. The beat with is_last set closes the
// expression; the result beat then carries the top of the stack and a status
// (underflow, overflow, divide by zero or bad final depth, value 0 on error).
// Timing: the block takes one character at a time. A digit passes the decode
// and end states; an operator adds operand check, operand load, calculate and
// push, and a divide waits before push while the divider resolves one quotient
// bit per cycle. A last character adds a flush state before the result beat.
// The output register lets a new expression start while the previous result
// still waits; if the receiver holds out_stall, the next result waits in the
// controller and the input stays stalled until the pending beat is taken.
// Reset clears the stack depth, the number in progress, the first-error code
// and the output valid; stack memory contents are not cleared and need not be.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Commands flow from the controller to the datapath, status flows back.
  cmd_t  cmd;
  stat_t stat;

  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: hdl/pee_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/pee_div.sv
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle; the quotient
// truncates toward zero.
// ----------------------------------------------------------------------------
module pee_div
  import pee_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quot
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] q_r, q_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] mb_r, mb_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, q_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, mb_r};
  assign done    = busy_r && (cnt_r == '0);
  assign quot    = neg_r ? (DATA_W'(0) - q_r) : q_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    mb_nxt   = mb_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      q_nxt    = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
      mb_nxt   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      rem_nxt  = '0;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        q_nxt   = {q_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    mb_r  <= mb_nxt;
    neg_r <= neg_nxt;
  end

endmodule

// File: hdl/pee_dp.sv
// ----------------------------------------------------------------------------
// Postfix evaluator datapath
// Number accumulator, operand stack with a cached top entry, arithmetic unit,
// divider, error tracking and the output register.
// ----------------------------------------------------------------------------
module pee_dp
  import pee_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [7:0]        char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [DATA_W-1:0] accum_r, accum_nxt;
  logic              in_num_r, in_num_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  status_t           err_r, err_nxt;
  logic [DATA_W-1:0] tos_r, tos_nxt;
  logic [DATA_W-1:0] lhs_r, lhs_nxt;
  logic [DATA_W-1:0] rhs_r, rhs_nxt;
  logic [DATA_W-1:0] res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [CW-1:0]     cnt_m2;
  logic              full;
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;

  assign cnt_m2    = count_r - CW'(2);
  assign ram_raddr = cnt_m2[AW-1:0];
  assign full      = (count_r >= CW'(STACK_DEPTH));

  assign stat.is_digit = (char_r >= CH_ZERO) && (char_r <= CH_NINE);
  assign stat.is_op    = (char_r == CH_PLUS) || (char_r == CH_MINUS) ||
                         (char_r == CH_MUL)  || (char_r == CH_DIV);
  assign stat.is_div   = (char_r == CH_DIV);
  assign stat.is_last  = last_r;
  assign stat.under    = (count_r < CW'(2));
  assign stat.rhs_zero = (rhs_r == '0);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || !out_stall;

  assign div_start = cmd.calc && stat.is_div && !stat.rhs_zero;

  always_comb begin
    char_nxt      = char_r;
    last_nxt      = last_r;
    accum_nxt     = accum_r;
    in_num_nxt    = in_num_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    tos_nxt       = tos_r;
    lhs_nxt       = lhs_r;
    rhs_nxt       = rhs_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = accum_r;

    if (cmd.load_in) begin
      char_nxt = in_data.char_in;
      last_nxt = in_data.is_last;
    end

    if (cmd.acc_digit) begin
      accum_nxt  = (accum_r << 3) + (accum_r << 1) + DATA_W'(char_r[3:0]);
      in_num_nxt = 1'b1;
    end

    // A pending number goes onto the stack; a full stack drops it.
    if (cmd.flush && in_num_r) begin
      if (full) begin
        if (err_r == ST_OK) begin
          err_nxt = ST_OVER;
        end
      end else begin
        ram_we    = 1'b1;
        tos_nxt   = accum_r;
        count_nxt = count_r + CW'(1);
      end
      accum_nxt  = '0;
      in_num_nxt = 1'b0;
    end

    if (cmd.note_under && (err_r == ST_OK)) begin
      err_nxt = ST_UNDER;
    end

    if (cmd.load_opnd) begin
      lhs_nxt = ram_rdata;
      rhs_nxt = tos_r;
    end

    if (cmd.calc) begin
      priority if (char_r == CH_PLUS) begin
        res_nxt = lhs_r + rhs_r;
      end else if (char_r == CH_MINUS) begin
        res_nxt = lhs_r - rhs_r;
      end else if (char_r == CH_MUL) begin
        res_nxt = lhs_r * rhs_r;
      end else if (stat.rhs_zero) begin
        res_nxt = '0;
        if (err_r == ST_OK) begin
          err_nxt = ST_DIVZ;
        end
      end else begin
        // A nonzero divisor leaves the quotient to the divider.
        res_nxt = res_r;
      end
    end

    if (cmd.load_quot) begin
      res_nxt = div_quot;
    end

    // Two operands popped, one result pushed in their place.
    if (cmd.op_push) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_m2[AW-1:0];
      ram_wdata = res_r;
      tos_nxt   = res_r;
      count_nxt = count_r - CW'(1);
    end

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (err_r != ST_OK) begin
        out_data_nxt.result_value = '0;
        out_data_nxt.status       = err_r;
      end else if (count_r != CW'(1)) begin
        out_data_nxt.result_value = '0;
        out_data_nxt.status       = ST_DEPTH;
      end else begin
        out_data_nxt.result_value = $signed(tos_r);
        out_data_nxt.status       = ST_OK;
      end
      count_nxt  = '0;
      accum_nxt  = '0;
      in_num_nxt = 1'b0;
      err_nxt    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= '0;
      in_num_r    <= 1'b0;
      count_r     <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      in_num_r    <= in_num_nxt;
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    last_r     <= last_nxt;
    tos_r      <= tos_nxt;
    lhs_r      <= lhs_nxt;
    rhs_r      <= rhs_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pee_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lhs_r),
    .divisor  (rhs_r),
    .done     (div_done),
    .quot     (div_quot)
  );

endmodule

// File: hdl/pee_ctrl.sv
// ----------------------------------------------------------------------------
// Postfix evaluator controller
// Sequences one character at a time through decode, number flush, operator
// evaluation and, on the last character, result delivery.
// ----------------------------------------------------------------------------
module pee_ctrl
  import pee_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_digit) begin
          cmd.acc_digit = 1'b1;
          state_nxt     = S_END;
        end else begin
          cmd.flush = 1'b1;
          state_nxt = S_OPCHK;
        end
      end
      S_OPCHK: begin
        if (!stat.is_op) begin
          state_nxt = S_END;
        end else if (stat.under) begin
          cmd.note_under = 1'b1;
          state_nxt      = S_END;
        end else begin
          state_nxt = S_OPWAIT;
        end
      end
      S_OPWAIT: begin
        cmd.load_opnd = 1'b1;
        state_nxt     = S_OPCALC;
      end
      S_OPCALC: begin
        cmd.calc  = 1'b1;
        state_nxt = (stat.is_div && !stat.rhs_zero) ? S_DIVRUN : S_OPPUSH;
      end
      S_DIVRUN: begin
        if (stat.div_done) begin
          cmd.load_quot = 1'b1;
          state_nxt     = S_OPPUSH;
        end
      end
      S_OPPUSH: begin
        cmd.op_push = 1'b1;
        state_nxt   = S_END;
      end
      S_END: begin
        state_nxt = stat.is_last ? S_LASTFLUSH : S_IDLE;
      end
      S_LASTFLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/pee_chk.sv
// ----------------------------------------------------------------------------
// Postfix evaluator port checker
// Watches the top-level ports for handshake and sequencing errors.
// ----------------------------------------------------------------------------
module pee_chk
  import pee_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The block works on one character at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a character is still in progress");

  // A result only comes out of a character in progress.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without a character in progress");

  // Any error status carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.result_value == '0)
    else $error("error result with nonzero value");

endmodule

bind postfix_expression_evaluator pee_chk u_pee_chk (.*);
